FILE: src/cau_pkg.sv
`timescale 1ns / 1ps
// cau_pkg: shared types and constants for the complex arithmetic unit
// used by every cau_* module and by complex_arithmetic_unit; no dependencies
package cau_pkg;

  // default operand format, signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // operation codes
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // control that travels with each transaction down the pipeline
  typedef struct packed {
    logic    valid;
    action_t action;
    logic    dz;      // divisor is zero
    logic    ovf_re;  // real quotient magnitude beyond the field
    logic    ovf_im;  // imaginary quotient magnitude beyond the field
    logic    neg_re;  // real numerator negative
    logic    neg_im;  // imaginary numerator negative
  } ctl_t;

endpackage

FILE: src/cau_products.sv
`timescale 1ns / 1ps
// cau_products: input register, partial products and full-width sums
// depends on cau_pkg
module cau_products import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    action,
  input  logic signed [DATA_WIDTH-1:0]  a_real,
  input  logic signed [DATA_WIDTH-1:0]  a_imag,
  input  logic signed [DATA_WIDTH-1:0]  b_real,
  input  logic signed [DATA_WIDTH-1:0]  b_imag,
  output ctl_t                          ctl_c,
  output logic signed [2*DATA_WIDTH:0]  sum_re,
  output logic signed [2*DATA_WIDTH:0]  sum_im,
  output logic [2*DATA_WIDTH-1:0]       den
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;

  ctl_t ctl_a, ctl_a_next, ctl_b;
  logic signed [W-1:0]  ar, ai, br, bi;
  logic signed [PW-1:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [PW-1:0] m_ac, m_bd, m_ad, m_bc, m_cc, m_dd;
  logic                 is_as;
  logic signed [SW-1:0] e_ac, e_bd, e_ad, e_bc;
  logic signed [SW-1:0] sum_re_next, sum_im_next;

  // control for an accepted transaction
  always_comb begin
    ctl_a_next        = '0;
    ctl_a_next.valid  = in_valid;
    ctl_a_next.action = action_t'(action);
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_c <= '0;
    end else begin
      ctl_a <= ctl_a_next;
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    ar <= a_real;
    ai <= a_imag;
    br <= b_real;
    bi <= b_imag;
  end

  // six signed multipliers
  assign m_ac  = PW'(ar) * PW'(br);
  assign m_bd  = PW'(ai) * PW'(bi);
  assign m_ad  = PW'(ar) * PW'(bi);
  assign m_bc  = PW'(ai) * PW'(br);
  assign m_cc  = PW'(br) * PW'(br);
  assign m_dd  = PW'(bi) * PW'(bi);
  assign is_as = (ctl_a.action == ACT_ADD) || (ctl_a.action == ACT_SUB);

  // product register, add and subtract carry their operands instead
  always_ff @(posedge clk) begin
    p_ac <= is_as ? PW'(ar) : m_ac;
    p_bd <= is_as ? PW'(br) : m_bd;
    p_ad <= is_as ? PW'(ai) : m_ad;
    p_bc <= is_as ? PW'(bi) : m_bc;
    p_cc <= m_cc;
    p_dd <= m_dd;
  end

  assign e_ac = SW'(p_ac);
  assign e_bd = SW'(p_bd);
  assign e_ad = SW'(p_ad);
  assign e_bc = SW'(p_bc);

  // full-width sums per operation
  always_comb begin
    case (ctl_b.action)
      ACT_ADD: begin
        sum_re_next = e_ac + e_bd;
        sum_im_next = e_ad + e_bc;
      end
      ACT_SUB: begin
        sum_re_next = e_ac - e_bd;
        sum_im_next = e_ad - e_bc;
      end
      ACT_MUL: begin
        sum_re_next = e_ac - e_bd;
        sum_im_next = e_ad + e_bc;
      end
      default: begin
        sum_re_next = e_ac + e_bd;
        sum_im_next = e_bc - e_ad;
      end
    endcase
  end

  // sum register
  always_ff @(posedge clk) begin
    sum_re <= sum_re_next;
    sum_im <= sum_im_next;
    den    <= $unsigned(p_cc) + $unsigned(p_dd);
  end

endmodule

FILE: src/cau_divprep.sv
`timescale 1ns / 1ps
// cau_divprep: magnitude and product scaling, then overflow check and divider seed
// depends on cau_pkg
module cau_divprep import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctl_t                          ctl_c,
  input  logic signed [2*DATA_WIDTH:0]  sum_re,
  input  logic signed [2*DATA_WIDTH:0]  sum_im,
  input  logic [2*DATA_WIDTH-1:0]       den_c,
  output ctl_t                          ctl_e,
  output logic [2*DATA_WIDTH:0]         val_re,
  output logic [2*DATA_WIDTH:0]         val_im,
  output logic [2*DATA_WIDTH-1:0]       rem_re,
  output logic [2*DATA_WIDTH-1:0]       rem_im,
  output logic [DATA_WIDTH-1:0]         low_re,
  output logic [DATA_WIDTH-1:0]         low_im,
  output logic [2*DATA_WIDTH-1:0]       den_e
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int HW = SW + F - W;
  localparam int CW = (HW > PW) ? HW : PW;

  ctl_t ctl_d, ctl_d_next, ctl_e_next;
  logic [SW-1:0]   vd_re, vd_im, vd_re_next, vd_im_next;
  logic [SW-1:0]   mag_re, mag_im;
  logic [PW-1:0]   den_d;
  logic            neg_re, neg_im;
  logic [SW+F-1:0] nsh_re, nsh_im;
  logic [CW-1:0]   hi_re, hi_im;

  // magnitudes for divide, scaled product for multiply
  assign neg_re = sum_re[SW-1];
  assign neg_im = sum_im[SW-1];
  assign mag_re = neg_re ? (~sum_re + 1'b1) : sum_re;
  assign mag_im = neg_im ? (~sum_im + 1'b1) : sum_im;

  always_comb begin
    ctl_d_next = ctl_c;
    case (ctl_c.action)
      ACT_DIV: begin
        vd_re_next        = mag_re;
        vd_im_next        = mag_im;
        ctl_d_next.neg_re = neg_re;
        ctl_d_next.neg_im = neg_im;
        ctl_d_next.dz     = (den_c == '0);
      end
      ACT_MUL: begin
        vd_re_next = sum_re >>> F;
        vd_im_next = sum_im >>> F;
      end
      default: begin
        vd_re_next = sum_re;
        vd_im_next = sum_im;
      end
    endcase
  end

  // numerator shifted by the fraction, split into seed and low bits
  assign nsh_re = {vd_re, {F{1'b0}}};
  assign nsh_im = {vd_im, {F{1'b0}}};
  assign hi_re  = CW'(nsh_re[SW+F-1:W]);
  assign hi_im  = CW'(nsh_im[SW+F-1:W]);

  // quotient reaches 2^W when the seed already holds the divisor
  always_comb begin
    ctl_e_next = ctl_d;
    if (ctl_d.action == ACT_DIV) begin
      ctl_e_next.ovf_re = (hi_re >= CW'(den_d));
      ctl_e_next.ovf_im = (hi_im >= CW'(den_d));
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
      ctl_e <= '0;
    end else begin
      ctl_d <= ctl_d_next;
      ctl_e <= ctl_e_next;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    vd_re  <= vd_re_next;
    vd_im  <= vd_im_next;
    den_d  <= den_c;
    val_re <= vd_re;
    val_im <= vd_im;
    rem_re <= hi_re[PW-1:0];
    rem_im <= hi_im[PW-1:0];
    low_re <= nsh_re[W-1:0];
    low_im <= nsh_im[W-1:0];
    den_e  <= den_d;
  end

endmodule

FILE: src/cau_divider.sv
`timescale 1ns / 1ps
// cau_divider: restoring divider, one quotient bit per pipeline stage, both parts
// depends on cau_pkg
module cau_divider import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctl_t                        ctl_i,
  input  logic [2*DATA_WIDTH:0]       val_re_i,
  input  logic [2*DATA_WIDTH:0]       val_im_i,
  input  logic [2*DATA_WIDTH-1:0]     rem_re_i,
  input  logic [2*DATA_WIDTH-1:0]     rem_im_i,
  input  logic [DATA_WIDTH-1:0]       low_re_i,
  input  logic [DATA_WIDTH-1:0]       low_im_i,
  input  logic [2*DATA_WIDTH-1:0]     den_i,
  output ctl_t                        ctl_o,
  output logic [2*DATA_WIDTH:0]       val_re_o,
  output logic [2*DATA_WIDTH:0]       val_im_o,
  output logic [DATA_WIDTH-1:0]       q_re_o,
  output logic [DATA_WIDTH-1:0]       q_im_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;

  ctl_t          ctl_s  [W+1];
  logic [SW-1:0] vre_s  [W+1];
  logic [SW-1:0] vim_s  [W+1];
  logic [PW-1:0] rre_s  [W+1];
  logic [PW-1:0] rim_s  [W+1];
  logic [W-1:0]  lre_s  [W+1];
  logic [W-1:0]  lim_s  [W+1];
  logic [W-1:0]  qre_s  [W+1];
  logic [W-1:0]  qim_s  [W+1];
  logic [PW-1:0] den_s  [W+1];
  logic [PW:0]   t_re   [W];
  logic [PW:0]   t_im   [W];
  logic [PW:0]   d_re   [W];
  logic [PW:0]   d_im   [W];
  logic          ge_re  [W];
  logic          ge_im  [W];

  // stage zero inputs
  assign ctl_s[0] = ctl_i;
  assign vre_s[0] = val_re_i;
  assign vim_s[0] = val_im_i;
  assign rre_s[0] = rem_re_i;
  assign rim_s[0] = rem_im_i;
  assign lre_s[0] = low_re_i;
  assign lim_s[0] = low_im_i;
  assign qre_s[0] = '0;
  assign qim_s[0] = '0;
  assign den_s[0] = den_i;

  for (genvar k = 0; k < W; k++) begin : g_stage
    // trial subtract
    assign t_re[k]  = {rre_s[k], lre_s[k][W-1]};
    assign t_im[k]  = {rim_s[k], lim_s[k][W-1]};
    assign d_re[k]  = t_re[k] - {1'b0, den_s[k]};
    assign d_im[k]  = t_im[k] - {1'b0, den_s[k]};
    assign ge_re[k] = (t_re[k] >= {1'b0, den_s[k]});
    assign ge_im[k] = (t_im[k] >= {1'b0, den_s[k]});

    // control pipeline
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k+1] <= '0;
      end else begin
        ctl_s[k+1] <= ctl_s[k];
      end
    end

    // remainder, quotient and pass-through registers
    always_ff @(posedge clk) begin
      rre_s[k+1] <= ge_re[k] ? d_re[k][PW-1:0] : t_re[k][PW-1:0];
      rim_s[k+1] <= ge_im[k] ? d_im[k][PW-1:0] : t_im[k][PW-1:0];
      lre_s[k+1] <= {lre_s[k][W-2:0], 1'b0};
      lim_s[k+1] <= {lim_s[k][W-2:0], 1'b0};
      qre_s[k+1] <= {qre_s[k][W-2:0], ge_re[k]};
      qim_s[k+1] <= {qim_s[k][W-2:0], ge_im[k]};
      vre_s[k+1] <= vre_s[k];
      vim_s[k+1] <= vim_s[k];
      den_s[k+1] <= den_s[k];
    end
  end

  assign ctl_o    = ctl_s[W];
  assign val_re_o = vre_s[W];
  assign val_im_o = vim_s[W];
  assign q_re_o   = qre_s[W];
  assign q_im_o   = qim_s[W];

endmodule

FILE: src/cau_saturate.sv
`timescale 1ns / 1ps
// cau_saturate: sign restore, clamp to the field and status, output register
// depends on cau_pkg
module cau_saturate import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ctl_t                         ctl,
  input  logic [2*DATA_WIDTH:0]        val_re,
  input  logic [2*DATA_WIDTH:0]        val_im,
  input  logic [DATA_WIDTH-1:0]        q_re,
  input  logic [DATA_WIDTH-1:0]        q_im,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] out_real,
  output logic signed [DATA_WIDTH-1:0] out_imag,
  output logic [1:0]                   status
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = 2 * W + 1;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] re_next, im_next;
  logic [1:0]   st_next;
  logic [W:0]   r_re, r_im;

  // clamp a wide signed value, result is {saturated, value}
  function automatic logic [W:0] clamp_lin(input logic [SW-1:0] v);
    logic [SW-W:0] hi;
    hi = v[SW-1:W-1];
    if ((&hi) || !(|hi)) begin
      clamp_lin = {1'b0, v[W-1:0]};
    end else begin
      clamp_lin = {1'b1, v[SW-1] ? MINV : MAXV};
    end
  endfunction

  // apply the sign to a quotient magnitude and clamp
  function automatic logic [W:0] clamp_div(input logic [W-1:0] q, input logic neg,
                                           input logic ovf);
    logic big;
    big = neg ? (q[W-1] && (|q[W-2:0])) : q[W-1];
    if (ovf || big) begin
      clamp_div = {1'b1, neg ? MINV : MAXV};
    end else begin
      clamp_div = {1'b0, neg ? (~q + 1'b1) : q};
    end
  endfunction

  // per-part result and status
  always_comb begin
    if (ctl.action == ACT_DIV) begin
      r_re = clamp_div(q_re, ctl.neg_re, ctl.ovf_re);
      r_im = clamp_div(q_im, ctl.neg_im, ctl.ovf_im);
    end else begin
      r_re = clamp_lin(val_re);
      r_im = clamp_lin(val_im);
    end
    if ((ctl.action == ACT_DIV) && ctl.dz) begin
      re_next = '0;
      im_next = '0;
      st_next = ST_DIV_ZERO;
    end else begin
      re_next = r_re[W-1:0];
      im_next = r_im[W-1:0];
      st_next = (r_re[W] || r_im[W]) ? ST_SAT : ST_OK;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_real <= re_next;
    out_imag <= im_next;
    status   <= st_next;
  end

endmodule

FILE: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// complex_arithmetic_unit: top level, add, subtract, multiply, divide of complex Q values
// depends on cau_pkg, cau_products, cau_divprep, cau_divider, cau_saturate

// A transaction is taken at every clock edge where start is high; busy is always
// low, so one operand pair may enter each cycle. Its result shows on out_real,
// out_imag and status for one cycle under done. Every operation alike runs
// through the full pipeline, whose length is set by the quotient divider
// producing one bit per stage. Results cannot be held off, so the receiver must
// take each one in the cycle done is high. Products round toward minus infinity,
// quotients truncate toward zero, out-of-range parts clamp with status 2, and a
// zero divisor returns zero with status 1.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] out_real,
  output logic signed [DATA_WIDTH-1:0] out_imag,
  output logic [1:0]                   status
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  ctl_t                 ctl_c, ctl_e, ctl_q;
  logic                 accept;
  logic signed [SW-1:0] sum_re, sum_im;
  logic [PW-1:0]        den_c, den_e, rem_re, rem_im;
  logic [SW-1:0]        val_re, val_im, dval_re, dval_im;
  logic [W-1:0]         low_re, low_im, q_re, q_im;

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cau_products #(.DATA_WIDTH(DATA_WIDTH)) u_products (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .action   (action),
    .a_real   (a_real),
    .a_imag   (a_imag),
    .b_real   (b_real),
    .b_imag   (b_imag),
    .ctl_c    (ctl_c),
    .sum_re   (sum_re),
    .sum_im   (sum_im),
    .den      (den_c)
  );

  cau_divprep #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_divprep (
    .clk    (clk),
    .rst    (rst),
    .ctl_c  (ctl_c),
    .sum_re (sum_re),
    .sum_im (sum_im),
    .den_c  (den_c),
    .ctl_e  (ctl_e),
    .val_re (val_re),
    .val_im (val_im),
    .rem_re (rem_re),
    .rem_im (rem_im),
    .low_re (low_re),
    .low_im (low_im),
    .den_e  (den_e)
  );

  cau_divider #(.DATA_WIDTH(DATA_WIDTH)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl_i    (ctl_e),
    .val_re_i (val_re),
    .val_im_i (val_im),
    .rem_re_i (rem_re),
    .rem_im_i (rem_im),
    .low_re_i (low_re),
    .low_im_i (low_im),
    .den_i    (den_e),
    .ctl_o    (ctl_q),
    .val_re_o (dval_re),
    .val_im_o (dval_im),
    .q_re_o   (q_re),
    .q_im_o   (q_im)
  );

  cau_saturate #(.DATA_WIDTH(DATA_WIDTH)) u_saturate (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_q),
    .val_re   (dval_re),
    .val_im   (dval_im),
    .q_re     (q_re),
    .q_im     (q_im),
    .done     (done),
    .out_real (out_real),
    .out_imag (out_imag),
    .status   (status)
  );

`ifndef SYNTHESIS
  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3))
    else $error("undefined status code");

  // divide by zero returns zero parts
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_DIV_ZERO)) |-> ((out_real == '0) && (out_imag == '0)))
    else $error("divide by zero result not zero");

  // a saturated transaction has at least one clamped part
  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_SAT)) |->
      ((out_real == MAXV) || (out_real == MINV) ||
       (out_imag == MAXV) || (out_imag == MINV)))
    else $error("saturation flagged without a clamped part");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe after reset");
`endif

endmodule

FILE: test/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// complex_arithmetic_unit_tb: self-checking bench for the complex arithmetic unit
// depends on cau_pkg and complex_arithmetic_unit; directed and random transactions

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [DW-1:0] MINV = 32'sh80000000;

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [1:0] st;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = ACT_ADD;
  logic signed [DW-1:0] a_real = '0;
  logic signed [DW-1:0] a_imag = '0;
  logic signed [DW-1:0] b_real = '0;
  logic signed [DW-1:0] b_imag = '0;
  logic done;
  logic signed [DW-1:0] out_real;
  logic signed [DW-1:0] out_imag;
  logic [1:0] status;

  cplx_result_t pending_results[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int cycles = 0;
  bit no_idle = 0;
  int op_count[4] = '{0, 0, 0, 0};

  complex_arithmetic_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .done(done), .out_real(out_real), .out_imag(out_imag), .status(status)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clamp a wide value to the field, flag when clamped
  function automatic logic signed [DW-1:0] clamp(input logic signed [255:0] x,
                                                 inout bit sat);
    if (x > 256'sh7fffffff) begin
      sat = 1;
      return MAXV;
    end else if (x < -256'sh80000000) begin
      sat = 1;
      return MINV;
    end
    return x[DW-1:0];
  endfunction

  // signed division truncating toward zero, divisor positive
  function automatic logic signed [255:0] div_trunc(input logic signed [255:0] n,
                                                    input logic signed [255:0] d);
    logic signed [255:0] q;
    q = (n < 0) ? -((-n) / d) : n / d;
    return q;
  endfunction

  // expected complex result for one transaction
  function automatic cplx_result_t complex_result(input logic [1:0] op,
      input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
      input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
    logic signed [255:0] a, b, c, d, re, im, den;
    cplx_result_t r;
    bit sat;
    a = ar;
    b = ai;
    c = br;
    d = bi;
    sat = 0;
    case (op)
      ACT_ADD: begin
        re = a + c;
        im = b + d;
      end
      ACT_SUB: begin
        re = a - c;
        im = b - d;
      end
      ACT_MUL: begin
        re = (a * c - b * d) >>> FB;
        im = (a * d + b * c) >>> FB;
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.st = ST_DIV_ZERO;
          return r;
        end
        re = div_trunc((a * c + b * d) <<< FB, den);
        im = div_trunc((b * c - a * d) <<< FB, den);
      end
    endcase
    r.re = clamp(re, sat);
    r.im = clamp(im, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // send one transaction, with occasional idle cycles first
  task automatic send_op(input logic [1:0] op, input logic signed [DW-1:0] ar,
                         input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                         input logic signed [DW-1:0] bi);
    while (!no_idle && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= op;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(complex_result(op, ar, ai, br, bi));
    op_count[op]++;
    sent++;
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected result has come
  task automatic drain();
    release_start();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_field();
    case ($urandom_range(7))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return $signed(32'($urandom_range(2 << FB))) - (1 <<< FB);
      4: return $signed(32'($urandom_range(32'h00ffffff))) - 32'sh00800000;
      default: return $signed($urandom());
    endcase
  endfunction

  // field extremes, every operation, zero divisor, saturation
  task automatic test_directed();
    logic [1:0] op;
    for (int k = 0; k < 4; k++) begin
      op = k[1:0];
      send_op(op, MAXV, MINV, MAXV, MINV);
      send_op(op, MINV, MAXV, MINV, MAXV);
      send_op(op, 32'sh00010000, -32'sh00020000, 32'sh00030000, 32'sh00008000);
      send_op(op, -1, 1, -1, 1);
    end
    send_op(ACT_DIV, 32'sh00050000, 32'sh00070000, '0, '0);
    send_op(ACT_DIV, '0, '0, '0, '0);
    send_op(ACT_DIV, MAXV, MAXV, 32'sh00000001, '0);
    send_op(ACT_DIV, -7, 3, 32'sh00020000, '0);
    send_op(ACT_MUL, -1, '0, 1, '0);
    send_op(ACT_MUL, MINV, MINV, MINV, MINV);
    send_op(ACT_ADD, MAXV, MINV, 1, -1);
    send_op(ACT_SUB, MINV, MAXV, 1, -1);
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      no_idle = (k >= n / 3) && (k < n / 2);
      send_op(2'($urandom_range(3)), rand_field(), rand_field(), rand_field(),
              rand_field());
    end
    no_idle = 0;
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_pause();
    drain();
    test_random(50);
  endtask

  // result checker
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %0d", out_real, out_imag, status);
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (out_real !== exp_r.re || out_imag !== exp_r.im || status !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %h %h %0d, got %h %h %0d", checked,
                     exp_r.re, exp_r.im, exp_r.st, out_real, out_imag, status);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[complex_arithmetic_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pause();
    test_random(1200);
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("sent %0d transactions (add %0d, sub %0d, mul %0d, div %0d), checked %0d",
             sent, op_count[0], op_count[1], op_count[2], op_count[3], checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[complex_arithmetic_unit] OK");
    end else begin
      $display("[complex_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cau_pkg.sv
src/cau_products.sv
src/cau_divprep.sv
src/cau_divider.sv
src/cau_saturate.sv
src/complex_arithmetic_unit.sv
test/complex_arithmetic_unit_tb.sv
